// ===== rtl/core/tapd_pkg.sv =====
// tapd_pkg: types, widths and helpers for the two-axis phase decoupling block
// used by every file in rtl/core; depends on nothing
`default_nettype none
package tapd_pkg;

    localparam int VOLTAGE_BITS  = 16;
    localparam int TAG_BITS      = 16;
    localparam int COEF_BITS     = 16;
    localparam int COEF_FRAC     = 14;
    localparam int CNT_BITS      = 13;
    localparam int RES_BITS      = 24;
    localparam int MAG_BITS      = 23;
    localparam int SUM_BITS      = 48;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam int MUL_BITS  = (VOLTAGE_BITS > RES_BITS) ? VOLTAGE_BITS : RES_BITS;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int NUM_BITS  = VOLTAGE_BITS + COEF_BITS + 1;
    localparam int DEN_BITS  = 2 * COEF_BITS + 1;
    localparam int NUMX_BITS = NUM_BITS + COEF_FRAC;
    localparam int DIVN_BITS = (NUMX_BITS > SUM_BITS) ? NUMX_BITS : SUM_BITS;
    localparam int DIVD_BITS = DEN_BITS;
    localparam int DCNT_BITS = $clog2(DIVN_BITS + 1);
    localparam int SQ_BITS   = 2 * RES_BITS;
    localparam int RT_BITS   = SQ_BITS / 2;
    localparam int SCNT_BITS = $clog2(RT_BITS + 1);

    typedef logic signed [VOLTAGE_BITS-1:0] t_volt;
    typedef logic signed [COEF_BITS-1:0]    t_coef;
    typedef logic signed [MUL_BITS-1:0]     t_mul;
    typedef logic signed [PROD_BITS-1:0]    t_prod;
    typedef logic signed [NUM_BITS-1:0]     t_num;
    typedef logic signed [DEN_BITS-1:0]     t_den;
    typedef logic signed [DIVN_BITS-1:0]    t_divn;
    typedef logic        [DIVN_BITS-1:0]    t_divu;
    typedef logic signed [DIVD_BITS-1:0]    t_divd;
    typedef logic        [DIVD_BITS-1:0]    t_divdu;
    typedef logic signed [RES_BITS-1:0]     t_res;
    typedef logic        [MAG_BITS-1:0]     t_mag;
    typedef logic        [SUM_BITS-1:0]     t_sum;
    typedef logic        [SQ_BITS-1:0]      t_sq;
    typedef logic        [RT_BITS-1:0]      t_root;

    localparam t_res X_MAX = {1'b0, {(RES_BITS-1){1'b1}}};
    localparam t_res X_MIN = {1'b1, {(RES_BITS-1){1'b0}}};
    localparam t_mag M_MAX = {MAG_BITS{1'b1}};
    localparam t_divu LIM_POS = t_divu'(X_MAX);
    localparam t_divu LIM_NEG = t_divu'(X_MAX) + t_divu'(1);

    localparam t_coef SIN_RESET = 16'sd0;
    localparam t_coef COS_RESET = 16'sd16384;
    localparam logic [CNT_BITS-1:0] CNT_RESET = 13'd225;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SIN_DRAG,
        CFG_COS_DRAG,
        CFG_SIN_LIFT,
        CFG_COS_LIFT,
        CFG_SAMPLE_COUNT
    } t_cfg_idx;

    typedef struct packed {
        t_coef               sin_drag;
        t_coef               cos_drag;
        t_coef               sin_lift;
        t_coef               cos_lift;
        logic [CNT_BITS-1:0] sample_count;
    } t_cfg;

    typedef struct packed {
        t_volt               drag;
        t_volt               lift;
        logic [TAG_BITS-1:0] tag;
        logic                last;
    } t_item;

    typedef struct packed {
        logic  start;
        t_divn dividend;
        t_divd divisor;
    } t_div_req;

    typedef enum logic [4:0] {
        B_IDLE, B_M0, B_M1, B_M2, B_M3, B_M4,
        B_DX, B_DXW, B_YM, B_YN, B_DY, B_DYW,
        B_SQ0, B_SQ1, B_SQ2, B_SQW, B_ACC,
        B_MX, B_MXW, B_MY, B_MYW, B_MM, B_MMW, B_OUT
    } t_bstate;

    function automatic t_res sat_res(input logic neg, input t_divu mag);
        t_res r;
        if (!neg) begin
            r = (mag > LIM_POS) ? X_MAX : mag[RES_BITS-1:0];
        end else begin
            r = (mag > LIM_NEG) ? X_MIN : -mag[RES_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_mag sat_mag(input logic neg, input t_divu mag);
        t_mag r;
        if (neg) begin
            r = '0;
        end else begin
            r = (mag > t_divu'(M_MAX)) ? M_MAX : mag[MAG_BITS-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tapd_in_if.sv =====
// tapd_in_if: input sample channel, valid/ready with the sample payload
// depends on tapd_pkg
`default_nettype none
interface tapd_in_if;
    logic                            valid;
    logic                            ready;
    tapd_pkg::t_volt                 drag_voltage;
    tapd_pkg::t_volt                 lift_voltage;
    logic [tapd_pkg::TAG_BITS-1:0]   angle_tag;
    logic                            last_sample;

    modport source (output valid, drag_voltage, lift_voltage, angle_tag, last_sample,
                    input ready);
    modport sink (input valid, drag_voltage, lift_voltage, angle_tag, last_sample,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tapd_out_if.sv =====
// tapd_out_if: result channel, valid/ready with the decoupled result payload
// depends on tapd_pkg
`default_nettype none
interface tapd_out_if;
    logic                            valid;
    logic                            ready;
    logic [tapd_pkg::TAG_BITS-1:0]   tag_out;
    tapd_pkg::t_res                  corrected_x;
    tapd_pkg::t_res                  corrected_y;
    tapd_pkg::t_mag                  magnitude;
    tapd_pkg::t_res                  mean_x;
    tapd_pkg::t_res                  mean_y;
    tapd_pkg::t_mag                  mean_magnitude;
    logic                            means_valid;
    logic                            divide_fault;

    modport source (output valid, tag_out, corrected_x, corrected_y, magnitude, mean_x,
                    mean_y, mean_magnitude, means_valid, divide_fault, input ready);
    modport sink (input valid, tag_out, corrected_x, corrected_y, magnitude, mean_x,
                  mean_y, mean_magnitude, means_valid, divide_fault, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tapd_front.sv =====
// tapd_front: accepts sample beats into a two-entry queue for the back end
// depends on tapd_pkg and tapd_in_if
`default_nettype none
module tapd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    tapd_in_if.sink            i_item,
    input  wire logic          i_pop,
    output tapd_pkg::t_item    o_item,
    output logic               o_valid
);
    tapd_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    logic            pop;

    assign i_item.ready = (r_cnt != 2'd2);
    assign push = i_item.valid && i_item.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = i_pop && o_valid;
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{drag: i_item.drag_voltage, lift: i_item.lift_voltage,
                             tag: i_item.angle_tag, last: i_item.last_sample};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) (r_cnt != 2'd3))
        else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("empty queue with unequal pointers");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count missed a push");
endmodule
`default_nettype wire

// ===== rtl/core/tapd_div.sv =====
// tapd_div: signed divider, one quotient bit per cycle, truncates toward zero
// depends on tapd_pkg
`default_nettype none
module tapd_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  tapd_pkg::t_div_req      i_req,
    output logic                    o_busy,
    output logic                    o_q_neg,
    output tapd_pkg::t_divu         o_q_mag
);
    tapd_pkg::t_divu                 r_q;
    tapd_pkg::t_divdu                r_den;
    logic [tapd_pkg::DIVD_BITS:0]    r_rem;
    logic [tapd_pkg::DCNT_BITS-1:0]  r_cnt;
    logic                            r_busy;
    logic                            r_neg;
    logic [tapd_pkg::DIVD_BITS+1:0]  trial;
    logic [tapd_pkg::DIVD_BITS+1:0]  rem_sh;

    assign rem_sh = {r_rem, r_q[tapd_pkg::DIVN_BITS-1]};
    assign trial  = rem_sh - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend[tapd_pkg::DIVN_BITS-1] ?
                     tapd_pkg::t_divu'(-i_req.dividend) : tapd_pkg::t_divu'(i_req.dividend);
            r_den <= i_req.divisor[tapd_pkg::DIVD_BITS-1] ?
                     tapd_pkg::t_divdu'(-i_req.divisor) : tapd_pkg::t_divdu'(i_req.divisor);
            r_neg <= i_req.dividend[tapd_pkg::DIVN_BITS-1] ^
                     i_req.divisor[tapd_pkg::DIVD_BITS-1];
            r_rem <= '0;
        end else if (r_busy) begin
            if (!trial[tapd_pkg::DIVD_BITS+1]) begin
                r_rem <= trial[tapd_pkg::DIVD_BITS:0];
                r_q   <= {r_q[tapd_pkg::DIVN_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[tapd_pkg::DIVD_BITS:0];
                r_q   <= {r_q[tapd_pkg::DIVN_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= tapd_pkg::DCNT_BITS'(tapd_pkg::DIVN_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == tapd_pkg::DCNT_BITS'(1)) r_busy <= 1'b0;
        end
    end

    assign o_busy  = r_busy;
    assign o_q_neg = r_neg;
    assign o_q_mag = r_q;
endmodule
`default_nettype wire

// ===== rtl/core/tapd_sqrt.sv =====
// tapd_sqrt: integer square root, one result bit per cycle, floor result
// depends on tapd_pkg
`default_nettype none
module tapd_sqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  tapd_pkg::t_sq      i_val,
    output logic               o_busy,
    output tapd_pkg::t_root    o_root
);
    localparam int REM_BITS = tapd_pkg::RT_BITS + 4;

    tapd_pkg::t_sq                   r_val;
    tapd_pkg::t_root                 r_root;
    logic [REM_BITS-1:0]             r_rem;
    logic [tapd_pkg::SCNT_BITS-1:0]  r_cnt;
    logic                            r_busy;
    logic [REM_BITS-1:0]             rem_sh;
    logic [REM_BITS-1:0]             trial;

    assign rem_sh = {r_rem[REM_BITS-3:0], r_val[tapd_pkg::SQ_BITS-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_val;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[tapd_pkg::SQ_BITS-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[tapd_pkg::RT_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[tapd_pkg::RT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= tapd_pkg::SCNT_BITS'(tapd_pkg::RT_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == tapd_pkg::SCNT_BITS'(1)) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== rtl/core/tapd_back.sv =====
// tapd_back: sequencer for the decoupling math, sums and output register
// depends on tapd_pkg, tapd_out_if, tapd_div and tapd_sqrt
`default_nettype none
module tapd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  tapd_pkg::t_cfg     i_cfg,
    input  tapd_pkg::t_item    i_item,
    input  wire logic          i_valid,
    output logic               o_pop,
    tapd_out_if.source         o_result
);
    tapd_pkg::t_bstate   r_state;
    tapd_pkg::t_bstate   n_state;
    tapd_pkg::t_volt     r_drag;
    tapd_pkg::t_volt     r_lift;
    logic [tapd_pkg::TAG_BITS-1:0] r_tag;
    logic                r_last;
    tapd_pkg::t_prod     r_prod;
    tapd_pkg::t_prod     r_acc;
    tapd_pkg::t_num      r_num;
    tapd_pkg::t_den      r_den;
    tapd_pkg::t_res      r_x;
    tapd_pkg::t_res      r_y;
    tapd_pkg::t_mag      r_mag;
    logic                r_fault;
    tapd_pkg::t_sum      r_sum_x;
    tapd_pkg::t_sum      r_sum_y;
    tapd_pkg::t_sum      r_sum_m;
    tapd_pkg::t_res      r_mx;
    tapd_pkg::t_res      r_my;
    tapd_pkg::t_mag      r_mm;
    logic                r_ovalid;

    tapd_pkg::t_mul      mul_a;
    tapd_pkg::t_mul      mul_b;
    tapd_pkg::t_prod     mul_p;
    tapd_pkg::t_div_req  div_req;
    logic                div_busy;
    logic                q_neg;
    tapd_pkg::t_divu     q_mag;
    logic                sq_start;
    logic                sq_busy;
    tapd_pkg::t_root     root;
    logic                load;
    logic [tapd_pkg::CNT_BITS-1:0] cnt;

    assign cnt = (i_cfg.sample_count == '0) ?
                 {{(tapd_pkg::CNT_BITS-1){1'b0}}, 1'b1} : i_cfg.sample_count;
    assign mul_p = mul_a * mul_b;

    tapd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_q_neg (q_neg),
        .o_q_mag (q_mag)
    );

    tapd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (r_acc[tapd_pkg::SQ_BITS-1:0] + r_prod[tapd_pkg::SQ_BITS-1:0]),
        .o_busy  (sq_busy),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tapd_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        div_req  = '0;
        sq_start = 1'b0;
        load     = 1'b0;
        unique case (r_state)
            tapd_pkg::B_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_state = tapd_pkg::B_M0;
                end
            end
            tapd_pkg::B_M0: begin
                mul_a   = tapd_pkg::t_mul'(r_drag);
                mul_b   = tapd_pkg::t_mul'(i_cfg.cos_lift);
                n_state = tapd_pkg::B_M1;
            end
            tapd_pkg::B_M1: begin
                mul_a   = tapd_pkg::t_mul'(r_lift);
                mul_b   = tapd_pkg::t_mul'(i_cfg.sin_drag);
                n_state = tapd_pkg::B_M2;
            end
            tapd_pkg::B_M2: begin
                mul_a   = tapd_pkg::t_mul'(i_cfg.cos_drag);
                mul_b   = tapd_pkg::t_mul'(i_cfg.cos_lift);
                n_state = tapd_pkg::B_M3;
            end
            tapd_pkg::B_M3: begin
                mul_a   = tapd_pkg::t_mul'(i_cfg.sin_drag);
                mul_b   = tapd_pkg::t_mul'(i_cfg.sin_lift);
                n_state = tapd_pkg::B_M4;
            end
            tapd_pkg::B_M4: n_state = tapd_pkg::B_DX;
            tapd_pkg::B_DX: begin
                if (r_den == '0) begin
                    n_state = tapd_pkg::B_YM;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = tapd_pkg::t_divn'(r_num) <<< tapd_pkg::COEF_FRAC;
                    div_req.divisor  = tapd_pkg::t_divd'(r_den);
                    n_state          = tapd_pkg::B_DXW;
                end
            end
            tapd_pkg::B_DXW: if (!div_busy) n_state = tapd_pkg::B_YM;
            tapd_pkg::B_YM: begin
                mul_a   = tapd_pkg::t_mul'(i_cfg.cos_drag);
                mul_b   = tapd_pkg::t_mul'(r_x);
                n_state = tapd_pkg::B_YN;
            end
            tapd_pkg::B_YN: n_state = tapd_pkg::B_DY;
            tapd_pkg::B_DY: begin
                if (i_cfg.sin_drag == '0) begin
                    n_state = tapd_pkg::B_SQ0;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = tapd_pkg::t_divn'(r_acc);
                    div_req.divisor  = tapd_pkg::t_divd'(i_cfg.sin_drag);
                    n_state          = tapd_pkg::B_DYW;
                end
            end
            tapd_pkg::B_DYW: if (!div_busy) n_state = tapd_pkg::B_SQ0;
            tapd_pkg::B_SQ0: begin
                mul_a   = tapd_pkg::t_mul'(r_x);
                mul_b   = tapd_pkg::t_mul'(r_x);
                n_state = tapd_pkg::B_SQ1;
            end
            tapd_pkg::B_SQ1: begin
                mul_a   = tapd_pkg::t_mul'(r_y);
                mul_b   = tapd_pkg::t_mul'(r_y);
                n_state = tapd_pkg::B_SQ2;
            end
            tapd_pkg::B_SQ2: begin
                sq_start = 1'b1;
                n_state  = tapd_pkg::B_SQW;
            end
            tapd_pkg::B_SQW: if (!sq_busy) n_state = tapd_pkg::B_ACC;
            tapd_pkg::B_ACC: n_state = r_last ? tapd_pkg::B_MX : tapd_pkg::B_OUT;
            tapd_pkg::B_MX: begin
                div_req.start    = 1'b1;
                div_req.dividend = tapd_pkg::t_divn'(signed'(r_sum_x));
                div_req.divisor  = tapd_pkg::t_divd'(cnt);
                n_state          = tapd_pkg::B_MXW;
            end
            tapd_pkg::B_MXW: if (!div_busy) n_state = tapd_pkg::B_MY;
            tapd_pkg::B_MY: begin
                div_req.start    = 1'b1;
                div_req.dividend = tapd_pkg::t_divn'(signed'(r_sum_y));
                div_req.divisor  = tapd_pkg::t_divd'(cnt);
                n_state          = tapd_pkg::B_MYW;
            end
            tapd_pkg::B_MYW: if (!div_busy) n_state = tapd_pkg::B_MM;
            tapd_pkg::B_MM: begin
                div_req.start    = 1'b1;
                div_req.dividend = tapd_pkg::t_divn'(signed'(r_sum_m));
                div_req.divisor  = tapd_pkg::t_divd'(cnt);
                n_state          = tapd_pkg::B_MMW;
            end
            tapd_pkg::B_MMW: if (!div_busy) n_state = tapd_pkg::B_OUT;
            tapd_pkg::B_OUT: begin
                if (!r_ovalid || o_result.ready) begin
                    load    = 1'b1;
                    n_state = tapd_pkg::B_IDLE;
                end
            end
            default: n_state = tapd_pkg::B_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            tapd_pkg::B_IDLE: begin
                r_drag  <= i_item.drag;
                r_lift  <= i_item.lift;
                r_tag   <= i_item.tag;
                r_last  <= i_item.last;
                r_fault <= 1'b0;
            end
            tapd_pkg::B_M1: r_acc <= r_prod;
            tapd_pkg::B_M2: r_num <= tapd_pkg::t_num'(r_acc - r_prod);
            tapd_pkg::B_M3: r_acc <= r_prod;
            tapd_pkg::B_M4: r_den <= tapd_pkg::t_den'(r_acc + r_prod);
            tapd_pkg::B_DX: begin
                if (r_den == '0) begin
                    r_x     <= r_num[tapd_pkg::NUM_BITS-1] ? tapd_pkg::X_MIN : tapd_pkg::X_MAX;
                    r_fault <= 1'b1;
                end
            end
            tapd_pkg::B_DXW: if (!div_busy) r_x <= tapd_pkg::sat_res(q_neg, q_mag);
            tapd_pkg::B_YN: begin
                r_acc <= (tapd_pkg::t_prod'(r_drag) <<< tapd_pkg::COEF_FRAC) - r_prod;
            end
            tapd_pkg::B_DY: begin
                if (i_cfg.sin_drag == '0) begin
                    r_y     <= r_acc[tapd_pkg::PROD_BITS-1] ? tapd_pkg::X_MIN : tapd_pkg::X_MAX;
                    r_fault <= 1'b1;
                end
            end
            tapd_pkg::B_DYW: if (!div_busy) r_y <= tapd_pkg::sat_res(q_neg, q_mag);
            tapd_pkg::B_SQ1: r_acc <= r_prod;
            tapd_pkg::B_SQW: begin
                if (!sq_busy) begin
                    r_mag <= (root > tapd_pkg::t_root'(tapd_pkg::M_MAX)) ?
                             tapd_pkg::M_MAX : root[tapd_pkg::MAG_BITS-1:0];
                end
            end
            tapd_pkg::B_MXW: if (!div_busy) r_mx <= tapd_pkg::sat_res(q_neg, q_mag);
            tapd_pkg::B_MYW: if (!div_busy) r_my <= tapd_pkg::sat_res(q_neg, q_mag);
            tapd_pkg::B_MMW: if (!div_busy) r_mm <= tapd_pkg::sat_mag(q_neg, q_mag);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_m <= '0;
        end else if (r_state == tapd_pkg::B_ACC) begin
            r_sum_x <= r_sum_x + tapd_pkg::t_sum'(r_x);
            r_sum_y <= r_sum_y + tapd_pkg::t_sum'(r_y);
            r_sum_m <= r_sum_m + tapd_pkg::t_sum'(r_mag);
        end else if (load && r_last) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_m <= '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_result.tag_out        <= r_tag;
            o_result.corrected_x    <= r_x;
            o_result.corrected_y    <= r_y;
            o_result.magnitude      <= r_mag;
            o_result.mean_x         <= r_last ? r_mx : '0;
            o_result.mean_y         <= r_last ? r_my : '0;
            o_result.mean_magnitude <= r_last ? r_mm : '0;
            o_result.means_valid    <= r_last;
            o_result.divide_fault   <= r_fault;
        end
    end

    assign o_result.valid = r_ovalid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_busy)
        else $error("divider started while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_fault) |-> (r_den == '0 || i_cfg.sin_drag == '0))
        else $error("fault flagged with nonzero divisors");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_last) |=> (r_sum_x == '0 && r_sum_y == '0 && r_sum_m == '0))
        else $error("sums not cleared after last sample");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_result.means_valid) |->
        (o_result.mean_x == '0 && o_result.mean_y == '0 && o_result.mean_magnitude == '0))
        else $error("mean fields nonzero without means_valid");
endmodule
`default_nettype wire

// ===== rtl/core/two_axis_phase_decoupling.sv =====
// two_axis_phase_decoupling: top level, configuration registers, front queue and back end
// depends on tapd_pkg, tapd_in_if, tapd_out_if, tapd_front and tapd_back
//
// Each sample beat passes through the back end, which shares one 1-bit-per-cycle
// divider (48 steps per division; two divisions per sample, fewer when a divisor
// is zero, plus three for the run averages on the last sample of a run) and a
// 1-bit-per-cycle square root (24 steps), with four products on one shared
// multiplier in front. A two-entry queue takes new beats while the back end
// works, and a result register holds the finished beat until it is taken; a
// result that is not taken stalls the back end.
// Write configuration only while the block is idle.
`default_nettype none
module two_axis_phase_decoupling (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tapd_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  wire logic [tapd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    tapd_in_if.sink                                  i_item,
    tapd_out_if.source                               o_result
);
    tapd_pkg::t_cfg  r_cfg;
    tapd_pkg::t_item item;
    logic            item_valid;
    logic            pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sin_drag     <= tapd_pkg::SIN_RESET;
            r_cfg.cos_drag     <= tapd_pkg::COS_RESET;
            r_cfg.sin_lift     <= tapd_pkg::SIN_RESET;
            r_cfg.cos_lift     <= tapd_pkg::COS_RESET;
            r_cfg.sample_count <= tapd_pkg::CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tapd_pkg::CFG_SIN_DRAG: r_cfg.sin_drag <= tapd_pkg::t_coef'(i_cfg_data);
                tapd_pkg::CFG_COS_DRAG: r_cfg.cos_drag <= tapd_pkg::t_coef'(i_cfg_data);
                tapd_pkg::CFG_SIN_LIFT: r_cfg.sin_lift <= tapd_pkg::t_coef'(i_cfg_data);
                tapd_pkg::CFG_COS_LIFT: r_cfg.cos_lift <= tapd_pkg::t_coef'(i_cfg_data);
                tapd_pkg::CFG_SAMPLE_COUNT: begin
                    r_cfg.sample_count <= i_cfg_data[tapd_pkg::CNT_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    tapd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_item  (item),
        .o_valid (item_valid)
    );

    tapd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (item),
        .i_valid  (item_valid),
        .o_pop    (pop),
        .o_result (o_result)
    );
endmodule
`default_nettype wire

// ===== test/tb_two_axis_phase_decoupling.sv =====
// tb_two_axis_phase_decoupling: self-checking bench for the phase decoupling block,
// random and directed sample runs checked against a bit-true predictor
// depends on tapd_pkg, tapd_in_if, tapd_out_if and two_axis_phase_decoupling
`default_nettype none
module tb_two_axis_phase_decoupling;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint RMAX = 8388607;
    localparam longint RMIN = -8388608;

    typedef struct {
        logic [tapd_pkg::TAG_BITS-1:0] tag;
        tapd_pkg::t_res x;
        tapd_pkg::t_res y;
        tapd_pkg::t_mag mag;
        tapd_pkg::t_res mx;
        tapd_pkg::t_res my;
        tapd_pkg::t_mag mm;
        logic mv;
        logic fault;
    } t_decoupled;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    tapd_pkg::t_cfg_idx i_cfg_idx;
    logic [tapd_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    tapd_in_if  samp_if ();
    tapd_out_if res_if ();

    two_axis_phase_decoupling uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (samp_if.sink),
        .o_result   (res_if.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    longint m_sin_drag, m_cos_drag, m_sin_lift, m_cos_lift;
    logic [tapd_pkg::CNT_BITS-1:0] m_count;
    logic [tapd_pkg::SUM_BITS-1:0] acc_x, acc_y, acc_mag;

    tapd_pkg::t_item pending_samples[$];
    t_decoupled      expected_results[$];
    int              n_accepted;
    int              n_fail;
    logic            hold_done;
    int              hold_left;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, n_accepted);
        n_fail++;
    endtask

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint quot_sat(input longint num, input longint den, inout logic flt);
        if (den == 0) begin
            flt = 1'b1;
            return num >= 0 ? RMAX : RMIN;
        end
        return clamp(num / den, RMIN, RMAX);
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint run_mean(input logic [tapd_pkg::SUM_BITS-1:0] s,
                                        input longint cnt, input longint lo);
        logic signed [tapd_pkg::SUM_BITS-1:0] ss;
        longint v;
        ss = s;
        v = ss;
        return clamp(v / cnt, lo, RMAX);
    endfunction

    function automatic t_decoupled decouple(input tapd_pkg::t_item it);
        t_decoupled r;
        longint drag, lift, den, numx, numy, x, y, mag, cnt;
        logic flt;
        drag = it.drag;
        lift = it.lift;
        flt = 1'b0;
        den = m_cos_drag * m_cos_lift + m_sin_drag * m_sin_lift;
        numx = (drag * m_cos_lift - lift * m_sin_drag) * 16384;
        x = quot_sat(numx, den, flt);
        numy = drag * 16384 - m_cos_drag * x;
        y = quot_sat(numy, m_sin_drag, flt);
        mag = int_sqrt(longint'(x * x + y * y));
        if (mag > RMAX) mag = RMAX;
        acc_x += tapd_pkg::SUM_BITS'(x);
        acc_y += tapd_pkg::SUM_BITS'(y);
        acc_mag += tapd_pkg::SUM_BITS'(mag);
        r.tag = it.tag;
        r.x = tapd_pkg::t_res'(x);
        r.y = tapd_pkg::t_res'(y);
        r.mag = tapd_pkg::t_mag'(mag);
        r.mx = '0;
        r.my = '0;
        r.mm = '0;
        r.mv = it.last;
        r.fault = flt;
        if (it.last) begin
            cnt = (m_count == 0) ? 1 : longint'(m_count);
            r.mx = tapd_pkg::t_res'(run_mean(acc_x, cnt, RMIN));
            r.my = tapd_pkg::t_res'(run_mean(acc_y, cnt, RMIN));
            r.mm = tapd_pkg::t_mag'(run_mean(acc_mag, cnt, 0));
            acc_x = '0;
            acc_y = '0;
            acc_mag = '0;
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        int idle_pct;
        logic give;
        if (!i_rst_n) begin
            samp_if.valid <= 1'b0;
        end else begin
            if (samp_if.valid && samp_if.ready) begin
                expected_results.push_back(decouple(pending_samples.pop_front()));
                n_accepted++;
            end
            idle_pct = (n_accepted < 600) ? 9 : (n_accepted < 1200) ? 60 : 0;
            // a waiting beat stays offered until taken
            give = pending_samples.size() != 0 &&
                   ((samp_if.valid && !samp_if.ready) || $urandom_range(99) >= idle_pct);
            samp_if.valid <= give;
            if (give) begin
                samp_if.drag_voltage <= pending_samples[0].drag;
                samp_if.lift_voltage <= pending_samples[0].lift;
                samp_if.angle_tag    <= pending_samples[0].tag;
                samp_if.last_sample  <= pending_samples[0].last;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        int idle_pct;
        t_decoupled e;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    report("unexpected beat", res_if.tag_out, 0);
                end else begin
                    e = expected_results.pop_front();
                    if (res_if.tag_out !== e.tag) report("tag_out", res_if.tag_out, e.tag);
                    if (res_if.corrected_x !== e.x)
                        report("corrected_x", res_if.corrected_x, e.x);
                    if (res_if.corrected_y !== e.y)
                        report("corrected_y", res_if.corrected_y, e.y);
                    if (res_if.magnitude !== e.mag) report("magnitude", res_if.magnitude, e.mag);
                    if (res_if.mean_x !== e.mx) report("mean_x", res_if.mean_x, e.mx);
                    if (res_if.mean_y !== e.my) report("mean_y", res_if.mean_y, e.my);
                    if (res_if.mean_magnitude !== e.mm)
                        report("mean_magnitude", res_if.mean_magnitude, e.mm);
                    if (res_if.means_valid !== e.mv)
                        report("means_valid", res_if.means_valid, e.mv);
                    if (res_if.divide_fault !== e.fault)
                        report("divide_fault", res_if.divide_fault, e.fault);
                end
            end
            idle_pct = (n_accepted < 600) ? 60 : (n_accepted < 1200) ? 9 : 0;
            // long hold-off once, so the block backs up and stalls its input
            if (!hold_done && n_accepted >= 1300) begin
                hold_done <= 1'b1;
                hold_left <= 2000;
                res_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= $urandom_range(99) >= idle_pct;
            end
        end
    end

    task automatic write_reg(input tapd_pkg::t_cfg_idx idx, input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            tapd_pkg::CFG_SIN_DRAG:     m_sin_drag = longint'($signed(v));
            tapd_pkg::CFG_COS_DRAG:     m_cos_drag = longint'($signed(v));
            tapd_pkg::CFG_SIN_LIFT:     m_sin_lift = longint'($signed(v));
            tapd_pkg::CFG_COS_LIFT:     m_cos_lift = longint'($signed(v));
            tapd_pkg::CFG_SAMPLE_COUNT: m_count = v[tapd_pkg::CNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [15:0] sd, input logic [15:0] cd, input logic [15:0] sl,
                           input logic [15:0] cl, input logic [15:0] cnt);
        write_reg(tapd_pkg::CFG_SIN_DRAG, sd);
        write_reg(tapd_pkg::CFG_COS_DRAG, cd);
        write_reg(tapd_pkg::CFG_SIN_LIFT, sl);
        write_reg(tapd_pkg::CFG_COS_LIFT, cl);
        write_reg(tapd_pkg::CFG_SAMPLE_COUNT, cnt);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && expected_results.size() == 0);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic add_sample(input logic [15:0] d, input logic [15:0] l, input logic last);
        tapd_pkg::t_item it;
        it.drag = d;
        it.lift = l;
        it.tag  = 16'($urandom);
        it.last = last;
        pending_samples.push_back(it);
    endtask

    function automatic logic [15:0] pick_voltage();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int run_len;
        int k;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tapd_pkg::CFG_SIN_DRAG;
        i_cfg_data = '0;
        samp_if.valid = 1'b0;
        samp_if.drag_voltage = '0;
        samp_if.lift_voltage = '0;
        samp_if.angle_tag = '0;
        samp_if.last_sample = 1'b0;
        res_if.ready = 1'b0;
        n_accepted = 0;
        n_fail = 0;
        hold_done = 1'b0;
        hold_left = 0;
        m_sin_drag = 0;
        m_cos_drag = 16384;
        m_sin_lift = 0;
        m_cos_lift = 16384;
        m_count = 13'd225;
        acc_x = '0;
        acc_y = '0;
        acc_mag = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: zero sine of drag, y divisor faults
        add_sample(16'h7fff, 16'h7fff, 1'b0);
        add_sample(16'h8000, 16'h8000, 1'b0);
        add_sample(16'h0000, 16'h0000, 1'b0);
        add_sample(16'h7fff, 16'h8000, 1'b0);
        add_sample(16'h8000, 16'h7fff, 1'b1);
        drain();

        // tilted axes, count of one
        set_all(16'd2841, 16'd16135, 16'hf4e7, 16'd16384, 16'd1);
        add_sample(16'h1000, 16'h0800, 1'b1);
        add_sample(16'h7fff, 16'h8000, 1'b0);
        add_sample(16'h8000, 16'h7fff, 1'b1);
        drain();

        // zero divisor for x
        set_all(16'd16384, 16'd0, 16'd0, 16'd16384, 16'd0);
        add_sample(16'h1234, 16'h0100, 1'b0);
        add_sample(16'h8000, 16'h7fff, 1'b0);
        add_sample(16'h0000, 16'h0000, 1'b1);
        drain();

        // extreme coefficients, largest count
        set_all(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h1fff);
        add_sample(16'h7fff, 16'h7fff, 1'b0);
        add_sample(16'h8000, 16'h8000, 1'b0);
        add_sample(16'h7fff, 16'h0001, 1'b1);
        drain();
        set_all(16'h0001, 16'h8000, 16'h8000, 16'h0001, 16'd4096);
        add_sample(16'h7fff, 16'h8000, 1'b0);
        add_sample(16'h0001, 16'hffff, 1'b1);
        drain();

        for (k = 0; k < 12; k++) begin
            case (k % 4)
                0: set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom_range(8191)));
                1: set_all(16'($urandom_range(6000)), 16'(16384 - $urandom_range(2000)),
                           16'(-$urandom_range(6000)), 16'(16384 - $urandom_range(2000)),
                           16'($urandom_range(1, 64)));
                2: set_all(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                           16'($urandom_range(1, 4096)));
                default: set_all(16'($urandom), 16'd0, 16'd0, 16'($urandom),
                                 16'($urandom_range(1, 8)));
            endcase
            while (pending_samples.size() + 0 < 130) begin
                run_len = $urandom_range(1, 20);
                repeat (run_len - 1) add_sample(pick_voltage(), pick_voltage(), 1'b0);
                add_sample(pick_voltage(), pick_voltage(), 1'b1);
            end
            drain();
        end

        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
